// ----- hw/rtl/pdpd_pkg.sv -----
// Shared constants and register codes of the pulse-decay presence detector.
package pdpd_pkg;

    localparam int CAPTURE_LEN_DEF = 28;
    localparam int TAIL_START_DEF  = 19;

    localparam int IDX_W   = 5;
    localparam int SUM_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CFG_A_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX  = 12'd4095;
    localparam logic [SUM_W-1:0] HIST_TOP = 12'd2295;

    localparam logic [CFG_A_W-1:0] REG_SETTLE = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_CALIB  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_RANK   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_WINDOW = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_FAR    = 3'd5;

    localparam logic [12:0] SETTLE_RST = 13'd3000;
    localparam logic [11:0] CALIB_RST  = 12'd2000;
    localparam logic [11:0] RANK_RST   = 12'd400;
    localparam logic [5:0]  WINDOW_RST = 6'd50;
    localparam logic [5:0]  NEAR_RST   = 6'd45;
    localparam logic [6:0]  FAR_RST    = 7'd21;

    localparam logic [1:0] PH_SETTLE = 2'd0;
    localparam logic [1:0] PH_CALIB  = 2'd1;
    localparam logic [1:0] PH_DETECT = 2'd2;

endpackage

// ----- hw/rtl/pulse_decay_presence_detector.sv -----
// Top level of the pulse-decay presence detector.
// A capture's last beat gives its result through the tail-sum queue and the back end;
// the calibration start adds a clear of every histogram bin, calibration end a
// walk down the histogram bins from the top, and a window end a bit-serial divide.
// Throughput: one beat per cycle until the two-entry tail-sum queue fills.
// Reset (synchronous, active low) restores register defaults and the settling phase.
module pulse_decay_presence_detector #(
    parameter int CAPTURE_LEN = pdpd_pkg::CAPTURE_LEN_DEF,
    parameter int TAIL_START  = pdpd_pkg::TAIL_START_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_sample,
    input  logic                         i_first_of_capture,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_phase,
    output logic                         o_window_done,
    output logic [5:0]                   o_above_count,
    output logic [15:0]                  o_distance_q16,
    output logic                         o_object_present,
    output logic [11:0]                  o_threshold_sum,
    input  logic                         i_cfg_we,
    input  logic [pdpd_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [pdpd_pkg::CFG_W-1:0]   i_cfg_data
);
    logic                       q_full, q_nonempty, push, pop;
    logic [pdpd_pkg::SUM_W-1:0] push_sum, q_head;

    pdpd_front #(.CAPTURE_LEN(CAPTURE_LEN), .TAIL_START(TAIL_START)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample, .i_first_of_capture,
        .i_q_full(q_full), .o_push(push), .o_push_sum(push_sum)
    );

    pdpd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_push_sum(push_sum), .i_pop(pop),
        .o_full(q_full), .o_nonempty(q_nonempty), .o_head(q_head)
    );

    pdpd_back #(.CAPTURE_LEN(CAPTURE_LEN), .TAIL_START(TAIL_START)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_q_nonempty(q_nonempty), .i_q_head(q_head), .o_pop(pop),
        .o_valid, .i_stall, .o_phase, .o_window_done, .o_above_count,
        .o_distance_q16, .o_object_present, .o_threshold_sum
    );
endmodule

// ----- hw/rtl/pdpd_front.sv -----
// Front end: frames samples into captures and accumulates the tail sum.
module pdpd_front #(
    parameter int CAPTURE_LEN = pdpd_pkg::CAPTURE_LEN_DEF,
    parameter int TAIL_START  = pdpd_pkg::TAIL_START_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_sample,
    input  logic                       i_first_of_capture,
    input  logic                       i_q_full,
    output logic                       o_push,
    output logic [pdpd_pkg::SUM_W-1:0] o_push_sum
);
    localparam logic [pdpd_pkg::IDX_W:0] CL = (pdpd_pkg::IDX_W+1)'(CAPTURE_LEN);
    localparam logic [pdpd_pkg::IDX_W:0] TS = (pdpd_pkg::IDX_W+1)'(TAIL_START);

    logic [pdpd_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [pdpd_pkg::SUM_W-1:0] r_tsum, n_tsum;
    logic [pdpd_pkg::IDX_W:0]   idx;
    logic [pdpd_pkg::SUM_W:0]   sum_ext;
    logic [pdpd_pkg::SUM_W-1:0] base;
    logic                       accept, last;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        idx = i_first_of_capture ? '0 : {1'b0, r_idx};
        if (idx >= CL) idx = '0;
        base    = (idx == '0) ? '0 : r_tsum;
        sum_ext = {1'b0, base};
        if (idx >= TS) sum_ext = {1'b0, base} + {5'd0, i_sample};
        n_tsum  = sum_ext[pdpd_pkg::SUM_W] ? pdpd_pkg::SUM_MAX : sum_ext[pdpd_pkg::SUM_W-1:0];
        last    = !((idx + 1'b1) < CL);
        n_idx   = last ? '0 : pdpd_pkg::IDX_W'(idx + 1'b1);
    end

    assign o_push     = accept && last;
    assign o_push_sum = n_tsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_tsum <= '0;
        end else if (accept) begin
            r_idx  <= n_idx;
            r_tsum <= n_tsum;
        end
    end
endmodule

// ----- hw/rtl/pdpd_queue.sv -----
// Two-entry queue of tail sums between front and back.
module pdpd_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [pdpd_pkg::SUM_W-1:0] i_push_sum,
    input  logic                       i_pop,
    output logic                       o_full,
    output logic                       o_nonempty,
    output logic [pdpd_pkg::SUM_W-1:0] o_head
);
    logic [pdpd_pkg::SUM_W-1:0] r_ent [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_head     = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_push_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ----- hw/rtl/pdpd_back.sv -----
// Back end: phases, histogram, threshold walk, window decision and distance divide.
module pdpd_back #(
    parameter int CAPTURE_LEN = pdpd_pkg::CAPTURE_LEN_DEF,
    parameter int TAIL_START  = pdpd_pkg::TAIL_START_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pdpd_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [pdpd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_q_nonempty,
    input  logic [pdpd_pkg::SUM_W-1:0]   i_q_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_phase,
    output logic                         o_window_done,
    output logic [5:0]                   o_above_count,
    output logic [15:0]                  o_distance_q16,
    output logic                         o_object_present,
    output logic [11:0]                  o_threshold_sum
);
    localparam int TL = (CAPTURE_LEN > TAIL_START) ? (CAPTURE_LEN - TAIL_START) : 1;
    localparam logic [12:0] TL255 = 13'(TL * 255);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_HREAD  = 4'd3;
    localparam logic [3:0] S_HWRITE = 4'd4;
    localparam logic [3:0] S_WALK_A = 4'd5;
    localparam logic [3:0] S_WALK_B = 4'd6;
    localparam logic [3:0] S_MUL1   = 4'd7;
    localparam logic [3:0] S_MUL2   = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [12:0] r_settle;
    logic [11:0] r_calib, r_rank;
    logic [5:0]  r_win, r_near;
    logic [6:0]  r_far;

    logic [3:0]  r_st;
    logic [12:0] r_pc, r_seen;
    logic [23:0] r_total;
    logic [11:0] r_thr, r_ts, r_ptr, r_hrd;
    logic        r_cfgd, r_cal;
    logic [5:0]  r_wc, r_ac;
    logic [17:0] r_wt;
    logic [23:0] r_ma;
    logic [6:0]  r_mb, r_db;
    logic [12:0] r_da;
    logic [30:0] r_m1;
    logic [25:0] r_d1;
    logic [46:0] r_num;
    logic [32:0] r_den, r_rem;
    logic [5:0]  r_it;
    logic [1:0]  r_ph;
    logic        r_done, r_pres;
    logic [5:0]  r_cnt;

    logic [11:0] r_hist [0:pdpd_pkg::HIST_TOP];
    logic        hist_we;
    logic [11:0] hist_wd;

    logic        r_ov;
    logic [1:0]  r_oph;
    logic        r_odone, r_opres;
    logic [5:0]  r_ocnt;
    logic [15:0] r_odist;
    logic [11:0] r_othr;

    logic [17:0] wt_n;
    logic [5:0]  ac_n, wc_n, w_eff;
    logic [6:0]  c2, n2;
    logic [11:0] need, bin;
    logic [12:0] pc_n, seen_n;
    logic [33:0] rsh;
    logic        can_load;

    always_comb begin
        wt_n   = r_wt + 18'(r_ts);
        ac_n   = r_ac + ((r_ts > r_thr) ? 6'd1 : 6'd0);
        wc_n   = r_wc + 6'd1;
        w_eff  = (r_win == '0) ? 6'd1 : r_win;
        c2     = {ac_n, 1'b0};
        n2     = {r_near, 1'b0};
        need   = (r_calib == '0) ? 12'd1 : r_calib;
        bin    = (r_ts > pdpd_pkg::HIST_TOP) ? pdpd_pkg::HIST_TOP : r_ts;
        pc_n   = r_pc + 13'd1;
        seen_n = r_seen + {1'b0, r_hrd};
        rsh    = {r_rem, r_num[46]};
        hist_we = (r_st == S_CLEAR) || (r_st == S_HWRITE);
        hist_wd = (r_st == S_CLEAR) ? '0 :
                  ((r_hrd == pdpd_pkg::SUM_MAX) ? r_hrd : r_hrd + 12'd1);
    end

    assign can_load = !r_ov || !i_stall;
    assign o_pop    = (r_st == S_IDLE) && i_q_nonempty;

    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist[r_ptr] <= hist_wd;
        r_hrd <= r_hist[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= pdpd_pkg::SETTLE_RST;
            r_calib  <= pdpd_pkg::CALIB_RST;
            r_rank   <= pdpd_pkg::RANK_RST;
            r_win    <= pdpd_pkg::WINDOW_RST;
            r_near   <= pdpd_pkg::NEAR_RST;
            r_far    <= pdpd_pkg::FAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdpd_pkg::REG_SETTLE: r_settle <= i_cfg_data;
                pdpd_pkg::REG_CALIB:  r_calib  <= i_cfg_data[11:0];
                pdpd_pkg::REG_RANK:   r_rank   <= i_cfg_data[11:0];
                pdpd_pkg::REG_WINDOW: r_win    <= i_cfg_data[5:0];
                pdpd_pkg::REG_NEAR:   r_near   <= i_cfg_data[5:0];
                pdpd_pkg::REG_FAR:    r_far    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_pc    <= '0;
            r_total <= '0;
            r_thr   <= pdpd_pkg::HIST_TOP;
            r_cfgd  <= 1'b0;
            r_cal   <= 1'b0;
            r_wc    <= '0;
            r_ac    <= '0;
            r_wt    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall && r_st != S_EMIT) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_q_nonempty) begin
                        r_ts <= i_q_head;
                        r_st <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                    r_pres <= 1'b0;
                    if (r_cfgd) begin
                        r_ph <= pdpd_pkg::PH_DETECT;
                        r_st <= S_EMIT;
                        if (wc_n >= w_eff) begin
                            r_done <= 1'b1;
                            r_cnt  <= ac_n;
                            r_wc   <= '0;
                            r_ac   <= '0;
                            r_wt   <= '0;
                            if (ac_n > r_near) begin
                                r_pres <= 1'b1;
                                r_ma   <= 24'(wt_n);
                                r_mb   <= 7'd1;
                                r_da   <= 13'(wc_n);
                                r_db   <= 7'd1;
                                r_st   <= S_MUL1;
                            end else if (c2 > r_far) begin
                                r_pres <= 1'b1;
                                r_ma   <= r_total;
                                r_mb   <= c2 - r_far;
                                r_da   <= (r_pc == '0) ? 13'd1 : r_pc;
                                r_db   <= n2 - r_far;
                                r_st   <= S_MUL1;
                            end
                        end else begin
                            r_wc <= wc_n;
                            r_ac <= ac_n;
                            r_wt <= wt_n;
                        end
                    end else if (!r_cal && r_pc >= r_settle) begin
                        r_cal   <= 1'b1;
                        r_pc    <= '0;
                        r_total <= '0;
                        r_ptr   <= '0;
                        r_st    <= S_CLEAR;
                    end else if (!r_cal) begin
                        r_ph <= pdpd_pkg::PH_SETTLE;
                        r_pc <= pc_n;
                        r_st <= S_EMIT;
                    end else begin
                        r_ptr <= bin;
                        r_st  <= S_HREAD;
                    end
                end
                S_CLEAR: begin
                    if (r_ptr == pdpd_pkg::HIST_TOP) begin
                        r_ptr <= bin;
                        r_st  <= S_HREAD;
                    end else begin
                        r_ptr <= r_ptr + 12'd1;
                    end
                end
                S_HREAD: r_st <= S_HWRITE;
                S_HWRITE: begin
                    r_ph    <= pdpd_pkg::PH_CALIB;
                    r_total <= r_total + 24'(r_ts);
                    r_pc    <= pc_n;
                    if (pc_n >= {1'b0, need}) begin
                        r_ptr  <= pdpd_pkg::HIST_TOP;
                        r_seen <= '0;
                        r_st   <= S_WALK_A;
                    end else begin
                        r_st <= S_EMIT;
                    end
                end
                S_WALK_A: r_st <= S_WALK_B;
                S_WALK_B: begin
                    r_seen <= seen_n;
                    if (seen_n > {1'b0, r_rank} || r_ptr == '0) begin
                        r_thr  <= (seen_n > {1'b0, r_rank}) ? r_ptr : '0;
                        r_cfgd <= 1'b1;
                        r_cal  <= 1'b0;
                        r_wc   <= '0;
                        r_ac   <= '0;
                        r_wt   <= '0;
                        r_st   <= S_EMIT;
                    end else begin
                        r_ptr <= r_ptr - 12'd1;
                        r_st  <= S_WALK_A;
                    end
                end
                S_MUL1: begin
                    r_m1 <= 31'(r_ma * r_mb);
                    r_d1 <= 26'(r_da * TL255);
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_num <= 47'(r_m1 * 16'hFFFF);
                    r_den <= 33'(r_d1 * r_db);
                    r_rem <= '0;
                    r_it  <= '0;
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    if (rsh >= {1'b0, r_den}) begin
                        r_rem <= 33'(rsh - {1'b0, r_den});
                        r_num <= {r_num[45:0], 1'b1};
                    end else begin
                        r_rem <= rsh[32:0];
                        r_num <= {r_num[45:0], 1'b0};
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd46) r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_ov    <= 1'b1;
                        r_oph   <= r_ph;
                        r_odone <= r_done;
                        r_ocnt  <= r_cnt;
                        r_opres <= r_pres;
                        r_othr  <= r_thr;
                        r_odist <= !r_pres ? 16'd0 :
                                   ((|r_num[46:16]) ? 16'hFFFF : r_num[15:0]);
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_phase          = r_oph;
    assign o_window_done    = r_odone;
    assign o_above_count    = r_ocnt;
    assign o_distance_q16   = r_odist;
    assign o_object_present = r_opres;
    assign o_threshold_sum  = r_othr;
endmodule

// ----- hw/rtl/pdpd_checker.sv -----
// Port-level checks of the presence detector, bound to the top level.
module pdpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_phase,
    input logic        o_window_done,
    input logic [5:0]  o_above_count,
    input logic [15:0] o_distance_q16,
    input logic        o_object_present
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance_q16))
        else $error("stalled result beat dropped or changed");

    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_phase != 2'd3)
        else $error("bad phase");

    a_nowin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_window_done |->
            o_above_count == 6'd0 && o_distance_q16 == 16'd0 && !o_object_present)
        else $error("window fields set outside window end");

    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_object_present |-> o_distance_q16 == 16'd0)
        else $error("distance without presence");

    a_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_window_done |-> o_phase == pdpd_pkg::PH_DETECT)
        else $error("window end outside detection");
endmodule

bind pulse_decay_presence_detector pdpd_checker u_pdpd_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_phase, .o_window_done,
    .o_above_count, .o_distance_q16, .o_object_present
);

// ----- tb/pdpd_scoreboard.sv -----
// Scoreboard: beat-level predictor of the presence detector and result checker.
`timescale 1ns / 100ps
import pdpd_pkg::*;

typedef struct packed {
    logic [1:0]  phase;
    logic        window_done;
    logic [5:0]  above_count;
    logic [15:0] distance;
    logic        present;
    logic [11:0] threshold;
} pulse_result_t;

class pdpd_scoreboard;
    localparam int TL = CAPTURE_LEN_DEF - TAIL_START_DEF;
    localparam int HDEPTH = 2296;

    logic [12:0] settle;
    logic [11:0] calib, rank;
    logic [5:0]  win, near;
    logic [6:0]  far;

    int unsigned   beat_idx, tsum, pcnt, ctot, thr, wcnt, acnt, wtot;
    bit            configured, calibrating;
    int unsigned   hist [HDEPTH];
    pulse_result_t expected_q [$];
    int            fails;

    function void init();
        settle = SETTLE_RST; calib = CALIB_RST; rank = RANK_RST;
        win = WINDOW_RST; near = NEAR_RST; far = FAR_RST;
        beat_idx = 0; tsum = 0; pcnt = 0; ctot = 0; thr = HIST_TOP;
        wcnt = 0; acnt = 0; wtot = 0; configured = 0; calibrating = 0;
        foreach (hist[i]) hist[i] = 0;
        expected_q.delete();
        fails = 0;
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_SETTLE: settle = val[12:0];
            REG_CALIB:  calib = val[11:0];
            REG_RANK:   rank = val[11:0];
            REG_WINDOW: win = val[5:0];
            REG_NEAR:   near = val[5:0];
            REG_FAR:    far = val[6:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void pick_threshold();
        int unsigned seen;
        seen = 0;
        thr = 0;
        for (int v = HIST_TOP; v >= 0; v--) begin
            seen += hist[v];
            if (seen > rank) begin
                thr = v;
                return;
            end
        end
    endfunction

    function void note_beat(logic [7:0] s, logic first);
        int unsigned       idx, ts, w, c, n, f, need, b;
        longint unsigned   d, p;
        pulse_result_t     r;
        idx = first ? 0 : beat_idx;
        if (idx >= CAPTURE_LEN_DEF) idx = 0;
        if (idx == 0) tsum = 0;
        if (idx >= TAIL_START_DEF) begin
            tsum += s;
            if (tsum > SUM_MAX) tsum = SUM_MAX;
        end
        if (idx + 1 < CAPTURE_LEN_DEF) begin
            beat_idx = idx + 1;
            return;
        end
        beat_idx = 0;
        ts = tsum;
        r = '0;
        if (configured) begin
            w = (win != 0) ? win : 1;
            r.phase = PH_DETECT;
            wtot += ts;
            if (ts > thr) acnt++;
            wcnt++;
            if (wcnt >= w) begin
                c = acnt; n = near; f = far;
                r.window_done = 1;
                r.above_count = c[5:0];
                if (c > n) begin
                    r.present = 1;
                    d = longint'(wtot) * 65535 / (longint'(wcnt) * TL * 255);
                    r.distance = (d > 65535) ? 16'hFFFF : d[15:0];
                end else if (2 * c > f) begin
                    p = (pcnt != 0) ? pcnt : 1;
                    r.present = 1;
                    d = longint'(ctot) * (2 * c - f) * 65535 /
                        (p * TL * 255 * longint'(2 * n - f));
                    r.distance = (d > 65535) ? 16'hFFFF : d[15:0];
                end
                wcnt = 0; acnt = 0; wtot = 0;
            end
        end else begin
            if (!calibrating && pcnt >= settle) begin
                calibrating = 1; pcnt = 0; ctot = 0;
                foreach (hist[i]) hist[i] = 0;
            end
            if (!calibrating) begin
                r.phase = PH_SETTLE;
                pcnt++;
            end else begin
                need = (calib != 0) ? calib : 1;
                b = (ts > HIST_TOP) ? HIST_TOP : ts;
                r.phase = PH_CALIB;
                if (hist[b] < SUM_MAX) hist[b]++;
                ctot = (ctot + ts) & 24'hFFFFFF;
                pcnt++;
                if (pcnt >= need) begin
                    pick_threshold();
                    configured = 1; calibrating = 0;
                    wcnt = 0; acnt = 0; wtot = 0;
                end
            end
        end
        r.threshold = thr[11:0];
        expected_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    task check_result(pulse_result_t got);
        pulse_result_t want;
        if (expected_q.size() == 0) begin
            report("unexpected result beat", 1, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.phase != want.phase) report("phase", got.phase, want.phase);
        if (got.window_done != want.window_done)
            report("window_done", got.window_done, want.window_done);
        if (got.above_count != want.above_count)
            report("above_count", got.above_count, want.above_count);
        if (got.distance != want.distance)
            report("distance_q16", got.distance, want.distance);
        if (got.present != want.present)
            report("object_present", got.present, want.present);
        if (got.threshold != want.threshold)
            report("threshold_sum", got.threshold, want.threshold);
    endtask
endclass

// ----- tb/tb_top.sv -----
// Top-level testbench of the pulse-decay presence detector.
`timescale 1ns / 100ps
import pdpd_pkg::*;

module tb_top;
    localparam int IDLE_LIMIT = 20000;
    localparam int CAP = CAPTURE_LEN_DEF;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_stall;
    logic [7:0]          i_sample = 0;
    logic                i_first_of_capture = 0;
    logic                o_valid;
    logic                i_stall = 0;
    logic [1:0]          o_phase;
    logic                o_window_done;
    logic [5:0]          o_above_count;
    logic [15:0]         o_distance_q16;
    logic                o_object_present;
    logic [11:0]         o_threshold_sum;
    logic                i_cfg_we = 0;
    logic [CFG_A_W-1:0]  i_cfg_index = 0;
    logic [CFG_W-1:0]    i_cfg_data = 0;

    pdpd_scoreboard sb = new();
    int  burst_left = 0;
    int  stall_mode = 0;
    int  hold_token = 0, hold_seen = 0, hold_left = 0;
    int  idle_cycles = 0;
    bit  running = 0;

    pulse_decay_presence_detector u_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (running) begin
            if (i_valid && !o_stall) sb.note_beat(i_sample, i_first_of_capture);
            if (o_valid && !i_stall)
                sb.check_result('{o_phase, o_window_done, o_above_count,
                                  o_distance_q16, o_object_present, o_threshold_sum});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            i_stall <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1;
        end else begin
            case (stall_mode)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    task write_reg(logic [CFG_A_W-1:0] idx, int val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, val[CFG_W-1:0]);
    endtask

    task send_beat(logic [7:0] s, logic f);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid <= 1;
        i_sample <= s;
        i_first_of_capture <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task drain();
        i_valid <= 0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task send_capture();
        int lvl, spread, len;
        logic [7:0] s;
        lvl = $urandom_range(0, 255);
        spread = $urandom_range(0, 60);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CAP - 1) : CAP;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) s = 8'($urandom);
            else s = 8'(lvl + $urandom_range(0, spread) > 255 ? 255
                        : lvl + $urandom_range(0, spread));
            send_beat(s, (k == 0) ? ($urandom_range(0, 4) != 0)
                                  : ($urandom_range(0, 200) == 0));
        end
    endtask

    initial begin
        int calib_val, w, ncap;
        int win_pick [6];
        win_pick = '{0, 1, 2, 3, 5, 63};
        sb.init();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;
        @(posedge i_clk);

        calib_val = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        write_reg(REG_SETTLE, $urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        write_reg(REG_CALIB, calib_val);
        write_reg(REG_RANK, $urandom_range(0, calib_val + 1));
        write_reg(REG_WINDOW, 3);
        write_reg(REG_NEAR, 1);
        write_reg(REG_FAR, 1);
        i_cfg_we <= 0;

        send_beat(8'd0, 1);
        send_beat(8'd255, 0);
        send_beat(8'd255, 1);
        for (int k = 1; k < CAP; k++) send_beat(8'd255, 0);
        for (int k = 0; k < CAP; k++) send_beat(8'd0, 0);
        for (int k = 0; k < CAP; k++) send_beat(8'(k * 9), 0);

        for (int ph = 0; ph < 6; ph++) begin
            stall_mode = ph % 3;
            ncap = (ph == 2) ? 8 : 4;
            if (ph > 0) begin
                drain();
                w = win_pick[$urandom_range(0, 5)];
                write_reg(REG_WINDOW, w);
                case ($urandom_range(0, 3))
                    0: write_reg(REG_NEAR, 0);
                    1: write_reg(REG_NEAR, 63);
                    default: write_reg(REG_NEAR, $urandom_range(0, 6));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(REG_FAR, 0);
                    1: write_reg(REG_FAR, 126);
                    2: write_reg(REG_FAR, 127);
                    default: write_reg(REG_FAR, $urandom_range(0, 12));
                endcase
                if (ph == 4) begin
                    write_reg(REG_SETTLE, 8191);
                    write_reg(REG_CALIB, 4095);
                    write_reg(REG_RANK, 4094);
                end
                if (ph == 5) begin
                    write_reg(REG_RANK, 0);
                    write_reg(REG_CALIB, 1);
                end
                i_cfg_we <= 0;
            end
            if (ph == 2) hold_token++;
            for (int c = 0; c < ncap; c++) send_capture();
        end

        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
